// ===== sv/rdwr_pkg.sv =====
// Shared types and constants for the draw-without-replacement pool.
`default_nettype none
package rdwr_pkg;

  // Fixed field widths
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned VAL_W  = 10;
  localparam int unsigned WORD_W = 16;

  localparam logic [CNT_W-1:0] POOL_SIZE_RST = 11'd1024;

  // Input item kinds
  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_DRAW    = 1'b1;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_FILL    = 6'b000010,
    ST_MUL     = 6'b000100,
    ST_RD_IDX  = 6'b001000,
    ST_RD_LAST = 6'b010000,
    ST_WRITE   = 6'b100000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;        // transaction taken: latch word, clear fill counter
    logic fill_we;       // write one identity entry, advance fill counter
    logic mul;           // register the index product
    logic rd_last;       // read the last live entry, capture the drawn entry
    logic wr_hole;       // move last entry into the hole, emit draw result
    logic done_restart;  // load remaining count, emit restart result
    logic done_empty;    // emit empty-pool result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic n_zero;     // restart loads no entries
    logic fill_last;  // current fill entry is the final one
    logic rem_zero;   // pool is empty
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/rdwr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rdwr_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/rdwr_ctrl.sv =====
// Sequencing state machine for restart fill and draw steps.
`default_nettype none
module rdwr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic          mode_i,
  input  wire rdwr_pkg::sts_t sts_i,
  output rdwr_pkg::cmd_t     cmd_o,
  output logic               busy
);
  import rdwr_pkg::*;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (mode_i == MODE_RESTART) begin
            if (sts_i.n_zero) begin
              cmd_o.done_restart = 1'b1;
            end else begin
              state_d = ST_FILL;
            end
          end else if (sts_i.rem_zero) begin
            cmd_o.done_empty = 1'b1;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill_we = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.done_restart = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RD_IDX;
      end
      ST_RD_IDX: begin
        // read of the drawn slot is in flight
        state_d = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        cmd_o.rd_last = 1'b1;
        state_d       = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr_hole = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== sv/rdwr_dp.sv =====
// Datapath: pool memory, counters, index product and result registers.
`default_nettype none
module rdwr_dp #(
  parameter int unsigned POOL_DEPTH = 1024,
  parameter int unsigned RAND_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rdwr_pkg::cmd_t                  cmd_i,
  output rdwr_pkg::sts_t                       sts_o,
  input  wire logic [rdwr_pkg::WORD_W-1:0]     random_word_i,
  input  wire logic                            pool_size_we_i,
  input  wire logic [rdwr_pkg::CNT_W-1:0]      pool_size_i,
  output logic                                 result_valid_o,
  output logic      [rdwr_pkg::VAL_W-1:0]      drawn_value_o,
  output logic                                 pool_empty_o,
  output logic      [rdwr_pkg::CNT_W-1:0]      remaining_count_o
);
  import rdwr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(POOL_DEPTH);
  localparam int unsigned R_W    = (RAND_BITS < WORD_W) ? RAND_BITS : WORD_W;
  localparam int unsigned PROD_W = CNT_W + R_W;
  localparam logic [31:0] DEPTH_32 = 32'(POOL_DEPTH);

  logic [CNT_W-1:0]  pool_size_q;
  logic [CNT_W-1:0]  remaining_q;
  logic [CNT_W-1:0]  fill_cnt_q;
  logic [R_W-1:0]    word_q;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  val_q;
  logic              valid_q;

  logic [CNT_W-1:0]  sat_n;
  logic [CNT_W-1:0]  last;
  logic [CNT_W-1:0]  idx;
  logic [PROD_W-1:0] prod_d;
  logic [ADDR_W-1:0] idx_addr;
  logic [ADDR_W-1:0] last_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // Restart count saturated to the pool depth
  assign sat_n = (32'(pool_size_q) > DEPTH_32) ? CNT_W'(DEPTH_32) : pool_size_q;

  // Index = floor(remaining * r / 2^RAND_BITS), always below remaining
  assign prod_d    = PROD_W'(remaining_q) * PROD_W'(word_q);
  assign idx       = CNT_W'(prod_q >> RAND_BITS);
  assign last      = remaining_q - CNT_W'(1);
  assign idx_addr  = ADDR_W'(idx);
  assign last_addr = ADDR_W'(last);

  // Memory port selection
  assign ram_we    = cmd_i.fill_we | cmd_i.wr_hole;
  assign ram_waddr = cmd_i.fill_we ? ADDR_W'(fill_cnt_q) : idx_addr;
  assign ram_wdata = cmd_i.fill_we ? fill_cnt_q[VAL_W-1:0] : ram_rdata;
  assign ram_raddr = cmd_i.rd_last ? last_addr : idx_addr;

  rdwr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status
  assign sts_o.n_zero    = (sat_n == '0);
  assign sts_o.fill_last = (fill_cnt_q == sat_n - CNT_W'(1));
  assign sts_o.rem_zero  = (remaining_q == '0);

  // Control state: config register, remaining count, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= POOL_SIZE_RST;
      remaining_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      if (pool_size_we_i) begin
        pool_size_q <= pool_size_i;
      end
      if (cmd_i.done_restart) begin
        remaining_q <= sat_n;
      end else if (cmd_i.wr_hole) begin
        remaining_q <= last;
      end
      valid_q <= cmd_i.done_restart | cmd_i.done_empty | cmd_i.wr_hole;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q     <= random_word_i[R_W-1:0];
      fill_cnt_q <= '0;
    end else if (cmd_i.fill_we) begin
      fill_cnt_q <= fill_cnt_q + CNT_W'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.rd_last) begin
      val_q <= ram_rdata;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.done_restart) begin
      drawn_value_o     <= '0;
      pool_empty_o      <= 1'b0;
      remaining_count_o <= sat_n;
    end else if (cmd_i.done_empty) begin
      drawn_value_o     <= '0;
      pool_empty_o      <= 1'b1;
      remaining_count_o <= '0;
    end else if (cmd_i.wr_hole) begin
      drawn_value_o     <= val_q;
      pool_empty_o      <= 1'b0;
      remaining_count_o <= last;
    end
  end

  assign result_valid_o = valid_q;

endmodule
`default_nettype wire

// ===== sv/random_draw_without_replacement.sv =====
// Top level of the draw-without-replacement pool.
//
//   channel   strobe / handshake          payload
//   input     start & !busy               mode_i, random_word_i
//   config    pool_size_we_i              pool_size_i
//   result    result_valid_o (one cycle)  drawn_value_o, pool_empty_o,
//                                         remaining_count_o
//
// A draw keeps busy high through the product, two reads through the single
// read port of the pool RAM, then the write of the hole; the result strobe
// is registered from the write of the hole.
// A restart writes one entry per cycle, pool_size entries (saturated to
// POOL_DEPTH). A draw on an empty pool or a restart of size zero never raises busy.
// After reset the pool is empty and pool_size is 1024. The receiver cannot
// stall; the result register lets a new transaction start while it shows.
`default_nettype none
module random_draw_without_replacement #(
  parameter int unsigned POOL_DEPTH = 1024,
  parameter int unsigned RAND_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            mode_i,
  input  wire logic [rdwr_pkg::WORD_W-1:0]     random_word_i,
  input  wire logic                            pool_size_we_i,
  input  wire logic [rdwr_pkg::CNT_W-1:0]      pool_size_i,
  output logic                                 result_valid_o,
  output logic      [rdwr_pkg::VAL_W-1:0]      drawn_value_o,
  output logic                                 pool_empty_o,
  output logic      [rdwr_pkg::CNT_W-1:0]      remaining_count_o
);
  import rdwr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rdwr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  rdwr_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .RAND_BITS  (RAND_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .random_word_i     (random_word_i),
    .pool_size_we_i    (pool_size_we_i),
    .pool_size_i       (pool_size_i),
    .result_valid_o    (result_valid_o),
    .drawn_value_o     (drawn_value_o),
    .pool_empty_o      (pool_empty_o),
    .remaining_count_o (remaining_count_o)
  );

endmodule
`default_nettype wire
